/* rtl/pnm_header_parser_core_macros.svh */
// Assertion macros for the PNM header parser.
// Each one expects clk and rst_n in scope.
`ifndef PNM_HEADER_PARSER_CORE_MACROS_SVH
`define PNM_HEADER_PARSER_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define PHP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define PHP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/php_pkg.sv */
package php_pkg;

    // Width of parsed numbers; each number saturates at all ones.
    localparam int VALUE_BITS = 31;
    // Room for value * 10 + 9 before saturation.
    localparam int ACC_BITS   = VALUE_BITS + 4;

    localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};

    // Character codes
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_4     = 8'h34;
    localparam logic [7:0] CH_6     = 8'h36;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;

    typedef enum logic [1:0] {
        ACT_DATA    = 2'd0,
        ACT_END     = 2'd1,
        ACT_RESTART = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_P       = 3'd1,
        ST_BAD_TYPE   = 3'd2,
        ST_NO_WIDTH   = 3'd3,
        ST_NO_HEIGHT  = 3'd4,
        ST_NO_MAXVAL  = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        IMG_P4 = 2'd0,
        IMG_P5 = 2'd1,
        IMG_P6 = 2'd2
    } image_t;

    typedef enum logic [3:0] {
        PH_MAGIC = 4'd0,
        PH_TYPE  = 4'd1,
        PH_SEP_W = 4'd2,
        PH_NUM_W = 4'd3,
        PH_SEP_H = 4'd4,
        PH_NUM_H = 4'd5,
        PH_SEP_M = 4'd6,
        PH_NUM_M = 4'd7,
        PH_DONE  = 4'd8
    } phase_t;

    typedef struct packed {
        status_t                status;
        image_t                 image_type;
        logic [VALUE_BITS-1:0]  image_width;
        logic [VALUE_BITS-1:0]  image_height;
        logic [VALUE_BITS-1:0]  max_value;
    } result_t;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_0) && (b <= CH_9);
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_NL);
    endfunction

endpackage

/* rtl/php_stream_if.sv */
// Header byte channel.
interface php_stream_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] data_byte;

    modport source (output valid, output action, output data_byte, input ready);
    modport sink   (input valid, input action, input data_byte, output ready);
endinterface

/* rtl/php_result_if.sv */
// Parsed header result channel.
interface php_result_if;
    logic                          valid;
    logic                          ready;
    logic [2:0]                    status;
    logic [1:0]                    image_type;
    logic [php_pkg::VALUE_BITS-1:0] image_width;
    logic [php_pkg::VALUE_BITS-1:0] image_height;
    logic [php_pkg::VALUE_BITS-1:0] max_value;

    modport source (output valid, output status, output image_type, output image_width,
                    output image_height, output max_value, input ready);
    modport sink   (input valid, input status, input image_type, input image_width,
                    input image_height, input max_value, output ready);
endinterface

/* rtl/pnm_header_parser_core.sv */
// Channel   Dir   Word                                   Note
// stream    in    action, data_byte                      one header byte or command
// result    out   status, image_type, width/height/max   at most one per header
//
// One word per cycle sustained while the result is taken; a word waits in the
// input stage, where the parse step (one 35-bit multiply-by-ten add and compare)
// runs, and the result lands in the output register on the edge the word leaves.
// A stalled result holds the input stage; stream.ready stays high while the
// result register is empty or being taken.
// rst_n clears parse state to "expect magic" and empties both stages.
`include "pnm_header_parser_core_macros.svh"

module pnm_header_parser_core
(
    input  logic                clk,
    input  logic                rst_n,
    php_stream_if.sink          stream,
    php_result_if.source        result
);

    // Input stage
    logic                 stage_valid_reg;
    logic [1:0]           stage_action_reg;
    logic [7:0]           stage_byte_reg;

    // Parse state
    php_pkg::phase_t                  phase_reg, phase_next;
    logic                             in_comment_reg, in_comment_next;
    logic [php_pkg::VALUE_BITS-1:0]   acc_reg, acc_next;
    logic [php_pkg::VALUE_BITS-1:0]   width_reg, width_next;
    logic [php_pkg::VALUE_BITS-1:0]   height_reg, height_next;
    php_pkg::image_t                  type_reg, type_next;

    // Output register
    logic                 out_valid_reg;
    php_pkg::result_t     out_data_reg;

    // Step logic
    logic                             out_free;
    logic                             stage_fire;
    logic                             emit;
    php_pkg::result_t                 res;
    logic                             do_sep;
    php_pkg::phase_t                  sep_num;
    php_pkg::status_t                 sep_err;
    logic [3:0]                       digit;
    logic [php_pkg::ACC_BITS-1:0]     acc_ext;
    logic [php_pkg::ACC_BITS-1:0]     acc_mul;
    logic [php_pkg::VALUE_BITS-1:0]   acc_sat;
    logic                             b_digit;

    // Handshake
    assign out_free     = !out_valid_reg || result.ready;
    assign stage_fire   = stage_valid_reg && out_free;
    assign stream.ready = !stage_valid_reg || out_free;

    // Decimal accumulate with saturation
    assign b_digit = php_pkg::is_digit(stage_byte_reg);
    assign digit   = 4'(stage_byte_reg - php_pkg::CH_0);
    assign acc_ext = php_pkg::ACC_BITS'(acc_reg);
    assign acc_mul = (acc_ext << 3) + (acc_ext << 1) + php_pkg::ACC_BITS'(digit);
    assign acc_sat = (acc_mul > php_pkg::ACC_BITS'(php_pkg::VALUE_MAX))
                   ? php_pkg::VALUE_MAX : acc_mul[php_pkg::VALUE_BITS-1:0];

    // Parse step for the word in the input stage
    always_comb
    begin
        phase_next      = phase_reg;
        in_comment_next = in_comment_reg;
        acc_next        = acc_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        type_next       = type_reg;
        emit            = 1'b0;
        res             = '0;
        do_sep          = 1'b0;
        sep_num         = php_pkg::PH_NUM_W;
        sep_err         = php_pkg::ST_NO_WIDTH;

        case (php_pkg::action_t'(stage_action_reg))
            php_pkg::ACT_DATA:
            begin
                case (phase_reg)
                    php_pkg::PH_MAGIC:
                    begin
                        if (in_comment_reg)
                        begin
                            if (stage_byte_reg == php_pkg::CH_NL)
                                in_comment_next = 1'b0;
                        end
                        else if (stage_byte_reg == php_pkg::CH_HASH)
                            in_comment_next = 1'b1;
                        else if (stage_byte_reg == php_pkg::CH_P)
                            phase_next = php_pkg::PH_TYPE;
                        else
                        begin
                            emit       = 1'b1;
                            res.status = php_pkg::ST_NO_P;
                        end
                    end
                    php_pkg::PH_TYPE:
                    begin
                        if (stage_byte_reg >= php_pkg::CH_4 && stage_byte_reg <= php_pkg::CH_6)
                        begin
                            // '4'..'6' carry the type in their low two bits
                            type_next  = php_pkg::image_t'(stage_byte_reg[1:0]);
                            phase_next = php_pkg::PH_SEP_W;
                        end
                        else
                        begin
                            emit       = 1'b1;
                            res.status = php_pkg::ST_BAD_TYPE;
                        end
                    end
                    php_pkg::PH_SEP_W:
                    begin
                        do_sep  = 1'b1;
                        sep_num = php_pkg::PH_NUM_W;
                        sep_err = php_pkg::ST_NO_WIDTH;
                    end
                    php_pkg::PH_NUM_W:
                    begin
                        if (b_digit)
                            acc_next = acc_sat;
                        else
                        begin
                            width_next = acc_reg;
                            phase_next = php_pkg::PH_SEP_H;
                            do_sep     = 1'b1;
                            sep_num    = php_pkg::PH_NUM_H;
                            sep_err    = php_pkg::ST_NO_HEIGHT;
                        end
                    end
                    php_pkg::PH_SEP_H:
                    begin
                        do_sep  = 1'b1;
                        sep_num = php_pkg::PH_NUM_H;
                        sep_err = php_pkg::ST_NO_HEIGHT;
                    end
                    php_pkg::PH_NUM_H:
                    begin
                        if (b_digit)
                            acc_next = acc_sat;
                        else
                        begin
                            height_next = acc_reg;
                            if (type_reg == php_pkg::IMG_P4)
                            begin
                                // any non-digit byte ends a bitmap header here
                                emit             = 1'b1;
                                res.status       = php_pkg::ST_OK;
                                res.image_type   = type_reg;
                                res.image_width  = width_reg;
                                res.image_height = acc_reg;
                            end
                            else
                            begin
                                phase_next = php_pkg::PH_SEP_M;
                                do_sep     = 1'b1;
                                sep_num    = php_pkg::PH_NUM_M;
                                sep_err    = php_pkg::ST_NO_MAXVAL;
                            end
                        end
                    end
                    php_pkg::PH_SEP_M:
                    begin
                        do_sep  = 1'b1;
                        sep_num = php_pkg::PH_NUM_M;
                        sep_err = php_pkg::ST_NO_MAXVAL;
                    end
                    php_pkg::PH_NUM_M:
                    begin
                        if (b_digit)
                            acc_next = acc_sat;
                        else
                        begin
                            emit             = 1'b1;
                            res.status       = php_pkg::ST_OK;
                            res.image_type   = type_reg;
                            res.image_width  = width_reg;
                            res.image_height = height_reg;
                            res.max_value    = acc_reg;
                        end
                    end
                    default:
                    begin
                        // finished: ignore until restart
                    end
                endcase

                // Separator handling between fields
                if (do_sep)
                begin
                    if (in_comment_reg)
                    begin
                        if (stage_byte_reg == php_pkg::CH_NL)
                            in_comment_next = 1'b0;
                    end
                    else if (php_pkg::is_space(stage_byte_reg))
                    begin
                        // skip
                    end
                    else if (stage_byte_reg == php_pkg::CH_HASH)
                        in_comment_next = 1'b1;
                    else if (b_digit)
                    begin
                        acc_next   = php_pkg::VALUE_BITS'(digit);
                        phase_next = sep_num;
                    end
                    else
                    begin
                        emit       = 1'b1;
                        res.status = sep_err;
                    end
                end
            end
            php_pkg::ACT_END:
            begin
                case (phase_reg)
                    php_pkg::PH_MAGIC:
                    begin
                        emit       = 1'b1;
                        res.status = php_pkg::ST_NO_P;
                    end
                    php_pkg::PH_TYPE:
                    begin
                        emit       = 1'b1;
                        res.status = php_pkg::ST_BAD_TYPE;
                    end
                    php_pkg::PH_SEP_W:
                    begin
                        emit       = 1'b1;
                        res.status = php_pkg::ST_NO_WIDTH;
                    end
                    php_pkg::PH_NUM_W,
                    php_pkg::PH_SEP_H:
                    begin
                        emit       = 1'b1;
                        res.status = php_pkg::ST_NO_HEIGHT;
                    end
                    php_pkg::PH_NUM_H:
                    begin
                        height_next = acc_reg;
                        emit        = 1'b1;
                        if (type_reg == php_pkg::IMG_P4)
                        begin
                            res.status       = php_pkg::ST_OK;
                            res.image_type   = type_reg;
                            res.image_width  = width_reg;
                            res.image_height = acc_reg;
                        end
                        else
                            res.status = php_pkg::ST_NO_MAXVAL;
                    end
                    php_pkg::PH_SEP_M:
                    begin
                        emit       = 1'b1;
                        res.status = php_pkg::ST_NO_MAXVAL;
                    end
                    php_pkg::PH_NUM_M:
                    begin
                        emit             = 1'b1;
                        res.status       = php_pkg::ST_OK;
                        res.image_type   = type_reg;
                        res.image_width  = width_reg;
                        res.image_height = height_reg;
                        res.max_value    = acc_reg;
                    end
                    default:
                    begin
                        // finished: ignore until restart
                    end
                endcase
            end
            php_pkg::ACT_RESTART:
            begin
                phase_next      = php_pkg::PH_MAGIC;
                in_comment_next = 1'b0;
                acc_next        = '0;
                width_next      = '0;
                height_next     = '0;
                type_next       = php_pkg::IMG_P4;
            end
            default:
            begin
                // unused action code: no effect
            end
        endcase

        // Any result ends the header
        if (emit)
        begin
            phase_next      = php_pkg::PH_DONE;
            in_comment_next = 1'b0;
        end
    end

    // Input stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else if (stream.ready)
            stage_valid_reg <= stream.valid;
    end

    always_ff @(posedge clk)
    begin
        if (stream.ready && stream.valid)
        begin
            stage_action_reg <= stream.action;
            stage_byte_reg   <= stream.data_byte;
        end
    end

    // Parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= php_pkg::PH_MAGIC;
            in_comment_reg <= 1'b0;
            acc_reg        <= '0;
            width_reg      <= '0;
            height_reg     <= '0;
            type_reg       <= php_pkg::IMG_P4;
        end
        else if (stage_fire)
        begin
            phase_reg      <= phase_next;
            in_comment_reg <= in_comment_next;
            acc_reg        <= acc_next;
            width_reg      <= width_next;
            height_reg     <= height_next;
            type_reg       <= type_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= stage_fire && emit;
    end

    always_ff @(posedge clk)
    begin
        if (stage_fire && emit)
            out_data_reg <= res;
    end

    assign result.valid        = out_valid_reg;
    assign result.status       = out_data_reg.status;
    assign result.image_type   = out_data_reg.image_type;
    assign result.image_width  = out_data_reg.image_width;
    assign result.image_height = out_data_reg.image_height;
    assign result.max_value    = out_data_reg.max_value;

    // Checks
    `PHP_ASSERT_NEXT(a_emit_done, stage_fire && emit, phase_reg == php_pkg::PH_DONE, "result did not finish header")
    `PHP_ASSERT_IMP(a_done_quiet, stage_valid_reg && phase_reg == php_pkg::PH_DONE, !emit, "result after header done")
    `PHP_ASSERT_IMP(a_comment_phase, in_comment_reg, phase_reg == php_pkg::PH_MAGIC || phase_reg == php_pkg::PH_SEP_W || phase_reg == php_pkg::PH_SEP_H || phase_reg == php_pkg::PH_SEP_M, "comment flag in number phase")
    `PHP_ASSERT_IMP(a_error_zero, out_valid_reg && out_data_reg.status != php_pkg::ST_OK, out_data_reg.image_type == php_pkg::IMG_P4 && out_data_reg.image_width == '0 && out_data_reg.image_height == '0 && out_data_reg.max_value == '0, "error result carries fields")
    `PHP_ASSERT_NEXT(a_stage_hold, stage_valid_reg && !out_free, stage_valid_reg && $stable(stage_byte_reg) && $stable(phase_reg), "stalled word lost")

endmodule
